@@ hw/rtl/framed_packet_parser_crc16_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Clocked assertions that are held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_CRC16_UNIT_ASSERT_SVH
`define FRAMED_PACKET_PARSER_CRC16_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FPP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication from a condition to a property in the next cycle.
`define FPP_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hw/rtl/fpp_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser package
// Shared constants, codes, control structures and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int LEN_W       = 7;
   localparam int IDX_W       = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;

   localparam logic [1:0] CSR_TIMEOUT     = 2'd0;
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd1;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd2;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_GOOD    = 2'd1,
      ST_CRC_ERR = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      PH_SYNC1 = 8'b0000_0001,
      PH_SYNC2 = 8'b0000_0010,
      PH_LEN   = 8'b0000_0100,
      PH_CMD   = 8'b0000_1000,
      PH_SEQ   = 8'b0001_0000,
      PH_PAY   = 8'b0010_0000,
      PH_CRCL  = 8'b0100_0000,
      PH_CRCH  = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE  = 3'b001,
      CS_FETCH = 3'b010,
      CS_LOAD  = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic step;
      logic fetch;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic burst;
      logic burst_last;
   } dp_status_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fpp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser controller
// Sequences word acceptance, the result register and payload bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "framed_packet_parser_crc16_unit_assert.svh"

module fpp_ctrl
   import fpp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CS_IDLE) && slot_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.step = 1'b1;
               if (dp_status.burst) begin
                  state_in = CS_FETCH;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         CS_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = CS_LOAD;
         end
         CS_LOAD: begin
            if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = dp_status.burst_last ? CS_IDLE : CS_FETCH;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FPP_ASSERT(a_cmd_exclusive, !(cmd.step && (cmd.fetch || cmd.load)),
      "step issued together with a burst command")
   `FPP_ASSERT_NEXT(a_burst_clears_slot, cmd.step && dp_status.burst, !rsp_valid_ff,
      "result register not empty at burst start")
   `FPP_ASSERT_NEXT(a_burst_continues, cmd.load && !dp_status.burst_last,
      state_ff == CS_FETCH, "burst ended before its last word")

endmodule

`default_nettype wire

@@ hw/rtl/fpp_datapath.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser datapath
// Frame parsing state, CRC, timeout check, payload memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "framed_packet_parser_crc16_unit_assert.svh"

module fpp_datapath
   import fpp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   output dp_status_type          dp_status,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [31:0]       now_ms,
   output logic [1:0]             status,
   output logic [LEN_W-1:0]       frame_size,
   output logic [7:0]             frame_command,
   output logic [7:0]             frame_sequence,
   output logic [7:0]             payload_byte,
   output logic [IDX_W-1:0]       byte_index,
   output logic                   payload_valid,
   output logic                   last
);

   logic [15:0] timeout_ff;
   logic [7:0]  sync_first_ff, sync_second_ff;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       sequence_ff, sequence_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       crc_low_ff, crc_low_in;
   logic [15:0]      crc_ff, crc_in;
   logic [31:0]      time_ff, time_in;
   logic             have_time_ff, have_time_in;

   logic [7:0]       payload_mem [MAX_PAYLOAD];
   logic             mem_we;
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] emit_ff;

   logic [15:0]      crc_base, crc_next;
   logic [LEN_W-1:0] fill_inc;
   logic [31:0]      gap;
   logic             gap_expired;
   logic             burst;
   status_type       step_status;
   logic [7:0]       step_command, step_sequence;

   logic [1:0]       status_ff;
   logic [LEN_W-1:0] frame_size_ff;
   logic [7:0]       frame_command_ff, frame_sequence_ff, payload_byte_ff;
   logic [IDX_W-1:0] byte_index_ff;
   logic             payload_valid_ff, last_ff;

   assign gap         = now_ms - time_ff;
   assign gap_expired = (phase_ff != PH_SYNC1) && have_time_ff && (gap > {16'd0, timeout_ff});
   assign crc_base    = (phase_ff == PH_LEN) ? CRC_INIT : crc_ff;
   assign crc_next    = crc16_update(crc_base, rx_byte);
   assign fill_inc    = fill_ff + LEN_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      len_in        = len_ff;
      command_in    = command_ff;
      sequence_in   = sequence_ff;
      fill_in       = fill_ff;
      crc_low_in    = crc_low_ff;
      crc_in        = crc_ff;
      time_in       = time_ff;
      have_time_in  = have_time_ff;
      mem_we        = 1'b0;
      burst         = 1'b0;
      step_status   = ST_NONE;
      step_command  = 8'd0;
      step_sequence = 8'd0;
      if (gap_expired) begin
         step_status  = ST_TIMEOUT;
         phase_in     = PH_SYNC1;
         fill_in      = '0;
         have_time_in = 1'b0;
         if (rx_byte == sync_first_ff) begin
            phase_in     = PH_SYNC2;
            time_in      = now_ms;
            have_time_in = 1'b1;
         end
      end else begin
         time_in      = now_ms;
         have_time_in = 1'b1;
         case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == sync_first_ff) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == sync_second_ff) begin
                  phase_in = PH_LEN;
               end else if (rx_byte != sync_first_ff) begin
                  phase_in     = PH_SYNC1;
                  fill_in      = '0;
                  have_time_in = 1'b0;
               end
            end
            PH_LEN: begin
               if (rx_byte > 8'(MAX_PAYLOAD)) begin
                  phase_in     = PH_SYNC1;
                  fill_in      = '0;
                  have_time_in = 1'b0;
               end else begin
                  len_in   = rx_byte[LEN_W-1:0];
                  fill_in  = '0;
                  crc_in   = crc_next;
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               command_in = rx_byte;
               crc_in     = crc_next;
               phase_in   = PH_SEQ;
            end
            PH_SEQ: begin
               sequence_in = rx_byte;
               crc_in      = crc_next;
               phase_in    = (len_ff == '0) ? PH_CRCL : PH_PAY;
            end
            PH_PAY: begin
               mem_we  = 1'b1;
               crc_in  = crc_next;
               fill_in = fill_inc;
               if (fill_inc >= len_ff) begin
                  phase_in = PH_CRCL;
               end
            end
            PH_CRCL: begin
               crc_low_in = rx_byte;
               phase_in   = PH_CRCH;
            end
            PH_CRCH: begin
               phase_in     = PH_SYNC1;
               fill_in      = '0;
               have_time_in = 1'b0;
               if ({rx_byte, crc_low_ff} == crc_ff) begin
                  step_status = ST_GOOD;
                  if (len_ff == '0) begin
                     step_command  = command_ff;
                     step_sequence = sequence_ff;
                  end else begin
                     burst = 1'b1;
                  end
               end else begin
                  step_status = ST_CRC_ERR;
                  if ((crc_low_ff == sync_first_ff) && (rx_byte == sync_second_ff)) begin
                     phase_in     = PH_LEN;
                     have_time_in = 1'b1;
                  end else if (rx_byte == sync_first_ff) begin
                     phase_in     = PH_SYNC2;
                     have_time_in = 1'b1;
                  end
               end
            end
            default: begin
               phase_in     = PH_SYNC1;
               fill_in      = '0;
               have_time_in = 1'b0;
            end
         endcase
      end
   end

   assign dp_status.burst      = burst;
   assign dp_status.burst_last = ({1'b0, emit_ff} + LEN_W'(1)) == len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIMEOUT:     timeout_ff     <= csr_wdata;
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         len_ff       <= '0;
         command_ff   <= '0;
         sequence_ff  <= '0;
         fill_ff      <= '0;
         crc_low_ff   <= '0;
         crc_ff       <= CRC_INIT;
         time_ff      <= '0;
         have_time_ff <= 1'b0;
         emit_ff      <= '0;
      end else begin
         if (cmd.step) begin
            phase_ff     <= phase_in;
            len_ff       <= len_in;
            command_ff   <= command_in;
            sequence_ff  <= sequence_in;
            fill_ff      <= fill_in;
            crc_low_ff   <= crc_low_in;
            crc_ff       <= crc_in;
            time_ff      <= time_in;
            have_time_ff <= have_time_in;
            emit_ff      <= '0;
         end else if (cmd.load) begin
            emit_ff <= emit_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && mem_we) begin
         payload_mem[fill_ff[IDX_W-1:0]] <= rx_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= payload_mem[emit_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && !burst) begin
         status_ff         <= step_status;
         frame_size_ff     <= '0;
         frame_command_ff  <= step_command;
         frame_sequence_ff <= step_sequence;
         payload_byte_ff   <= '0;
         byte_index_ff     <= '0;
         payload_valid_ff  <= 1'b0;
         last_ff           <= 1'b1;
      end else if (cmd.load) begin
         status_ff         <= ST_GOOD;
         frame_size_ff     <= len_ff;
         frame_command_ff  <= command_ff;
         frame_sequence_ff <= sequence_ff;
         payload_byte_ff   <= rd_data_ff;
         byte_index_ff     <= emit_ff;
         payload_valid_ff  <= 1'b1;
         last_ff           <= dp_status.burst_last;
      end
   end

   assign status         = status_ff;
   assign frame_size     = frame_size_ff;
   assign frame_command  = frame_command_ff;
   assign frame_sequence = frame_sequence_ff;
   assign payload_byte   = payload_byte_ff;
   assign byte_index     = byte_index_ff;
   assign payload_valid  = payload_valid_ff;
   assign last           = last_ff;

   `FPP_ASSERT(a_emit_in_frame, !(cmd.fetch || cmd.load) || ({1'b0, emit_ff} < len_ff),
      "burst index beyond stored length")

endmodule

`default_nettype wire

@@ hw/rtl/framed_packet_parser_crc16_unit.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser with CRC-16 check
// Top level: controller, datapath and the configuration write port.
// ----------------------------------------------------------------------------
// Each accepted word is one received byte with its millisecond timestamp and
// is parsed in the cycle it is taken while the result register is free;
// that register lets the next word in as soon as the current result is
// taken. A word that completes a good frame of L > 0 bytes starts a burst
// of L results, each read from the payload memory through its registered
// read port in a fetch state, then loaded into the result register in a
// load state that waits for it to be free; no word is accepted during the
// burst. Configuration writes are always ready and take effect next cycle.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_parser_crc16_unit
   import fpp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic [31:0]       req_now_ms,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_frame_size,
   output logic [7:0]             rsp_frame_command,
   output logic [7:0]             rsp_frame_sequence,
   output logic [7:0]             rsp_payload_byte,
   output logic [IDX_W-1:0]       rsp_byte_index,
   output logic                   rsp_payload_valid,
   output logic                   rsp_last,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   fpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   fpp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_status      (dp_status),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rx_byte        (req_rx_byte),
      .now_ms         (req_now_ms),
      .status         (rsp_status),
      .frame_size     (rsp_frame_size),
      .frame_command  (rsp_frame_command),
      .frame_sequence (rsp_frame_sequence),
      .payload_byte   (rsp_payload_byte),
      .byte_index     (rsp_byte_index),
      .payload_valid  (rsp_payload_valid),
      .last           (rsp_last)
   );

endmodule

`default_nettype wire

@@ tb/fpp_checker.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser checker
// Watches the byte, result and register channels, predicts every result word
// from the accepted bytes and compares each result field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpp_checker
   import fpp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [LEN_W-1:0]  rsp_frame_size,
   input  wire logic [7:0]        rsp_frame_command,
   input  wire logic [7:0]        rsp_frame_sequence,
   input  wire logic [7:0]        rsp_payload_byte,
   input  wire logic [IDX_W-1:0]  rsp_byte_index,
   input  wire logic              rsp_payload_valid,
   input  wire logic              rsp_last,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] frame_len;
      logic [7:0]       cmd;
      logic [7:0]       seq_no;
      logic [7:0]       data;
      logic [IDX_W-1:0] index;
      logic             data_valid;
      logic             last_word;
   } frame_word_type;

   frame_word_type   awaited_words[$];

   logic [15:0]      timeout_ms;
   logic [7:0]       sync_a;
   logic [7:0]       sync_b;

   phase_type        phase;
   logic [LEN_W-1:0] held_len;
   logic [7:0]       held_cmd;
   logic [7:0]       held_seq;
   logic [6:0]       fill;
   logic [7:0]       payload_mem [0:MAX_PAYLOAD-1];
   logic [7:0]       crc_lo;
   logic [15:0]      crc;
   logic [31:0]      stamp;
   logic             stamped;

   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      return r;
   endfunction

   task automatic await_word(input status_type st, input logic [LEN_W-1:0] len,
                             input logic [7:0] c, input logic [7:0] s,
                             input logic [7:0] d, input logic [IDX_W-1:0] i,
                             input logic v, input logic l);
      frame_word_type w;
      w = '{st, len, c, s, d, i, v, l};
      awaited_words.push_back(w);
   endtask

   task automatic restart_hunt();
      phase = PH_SYNC1;
      fill = '0;
      stamped = 1'b0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic [31:0] t);
      logic [31:0] gap;
      logic        pair;
      logic        first;
      gap = t - stamp;
      if (phase != PH_SYNC1 && stamped && gap > {16'd0, timeout_ms}) begin
         restart_hunt();
         if (b == sync_a) begin
            phase = PH_SYNC2;
            stamp = t;
            stamped = 1'b1;
         end
         await_word(ST_TIMEOUT, '0, '0, '0, '0, '0, 1'b0, 1'b1);
         return;
      end
      stamp = t;
      stamped = 1'b1;
      case (phase)
         PH_SYNC1: begin
            if (b == sync_a) phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (b == sync_b) phase = PH_LEN;
            else if (b != sync_a) restart_hunt();
         end
         PH_LEN: begin
            if (b > MAX_PAYLOAD) begin
               restart_hunt();
            end else begin
               held_len = b[LEN_W-1:0];
               fill = '0;
               crc = crc_next(CRC_INIT, b);
               phase = PH_CMD;
            end
         end
         PH_CMD: begin
            held_cmd = b;
            crc = crc_next(crc, b);
            phase = PH_SEQ;
         end
         PH_SEQ: begin
            held_seq = b;
            crc = crc_next(crc, b);
            phase = (held_len == 0) ? PH_CRCL : PH_PAY;
         end
         PH_PAY: begin
            payload_mem[fill[IDX_W-1:0]] = b;
            crc = crc_next(crc, b);
            fill = fill + 7'd1;
            if (fill >= held_len) phase = PH_CRCL;
         end
         PH_CRCL: begin
            crc_lo = b;
            phase = PH_CRCH;
         end
         default: begin
            if ({b, crc_lo} == crc) begin
               restart_hunt();
               if (held_len == 0) begin
                  await_word(ST_GOOD, '0, held_cmd, held_seq, '0, '0, 1'b0, 1'b1);
               end else begin
                  for (int i = 0; i < held_len; i++)
                     await_word(ST_GOOD, held_len, held_cmd, held_seq, payload_mem[i],
                                i[IDX_W-1:0], 1'b1, i == held_len - 1);
               end
               return;
            end
            pair = (crc_lo == sync_a) && (b == sync_b);
            first = (b == sync_a);
            restart_hunt();
            if (pair) begin
               phase = PH_LEN;
               stamp = t;
               stamped = 1'b1;
            end else if (first) begin
               phase = PH_SYNC2;
               stamp = t;
               stamped = 1'b1;
            end
            await_word(ST_CRC_ERR, '0, '0, '0, '0, '0, 1'b0, 1'b1);
            return;
         end
      endcase
      await_word(ST_NONE, '0, '0, '0, '0, '0, 1'b0, 1'b1);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      frame_word_type w;
      if (reset) begin
         timeout_ms = TIMEOUT_RESET;
         sync_a = SYNC_FIRST_RESET;
         sync_b = SYNC_SECOND_RESET;
         held_len = '0;
         held_cmd = '0;
         held_seq = '0;
         crc_lo = '0;
         crc = CRC_INIT;
         stamp = '0;
         restart_hunt();
         awaited_words.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT:     timeout_ms = csr_wdata;
               CSR_SYNC_FIRST:  sync_a = csr_wdata[7:0];
               CSR_SYNC_SECOND: sync_b = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: result word with none expected, status %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               w = awaited_words.pop_front();
               check_field("status", w.status, rsp_status);
               check_field("frame_size", w.frame_len, rsp_frame_size);
               check_field("frame_command", w.cmd, rsp_frame_command);
               check_field("frame_sequence", w.seq_no, rsp_frame_sequence);
               check_field("payload_byte", w.data, rsp_payload_byte);
               check_field("byte_index", w.index, rsp_byte_index);
               check_field("payload_valid", w.data_valid, rsp_payload_valid);
               check_field("last", w.last_word, rsp_last);
            end
         end
         if (req_valid && req_ready) parse_byte(req_rx_byte, req_now_ms);
      end
      pending_count = awaited_words.size();
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Framed packet parser testbench
// Feeds framed byte streams with timestamps under several register settings,
// with random idling on both sides, and lets the checker judge the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import fpp_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 12;

   typedef enum {
      FK_GOOD,
      FK_BAD_CRC,
      FK_RESYNC_PAIR,
      FK_RESYNC_FIRST,
      FK_OVERSIZE,
      FK_LATE
   } frame_kind_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic [7:0]        req_rx_byte = '0;
   logic [31:0]       req_now_ms  = '0;
   logic              rsp_ready   = 1'b0;
   logic              csr_valid   = 1'b0;
   logic [1:0]        csr_index   = CSR_TIMEOUT;
   logic [15:0]       csr_wdata   = '0;

   logic              req_ready;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [LEN_W-1:0]  rsp_frame_size;
   logic [7:0]        rsp_frame_command;
   logic [7:0]        rsp_frame_sequence;
   logic [7:0]        rsp_payload_byte;
   logic [IDX_W-1:0]  rsp_byte_index;
   logic              rsp_payload_valid;
   logic              rsp_last;
   logic              csr_ready;

   int                fail_count;
   int                pending_count;

   logic              no_idle     = 1'b0;
   int                hold_asks   = 0;
   int                hold_served = 0;
   int                hold_left   = 0;
   int                words_sent  = 0;
   logic [31:0]       stamp_ms;
   logic [15:0]       cur_timeout = TIMEOUT_RESET;
   logic [7:0]        cur_first   = SYNC_FIRST_RESET;
   logic [7:0]        cur_second  = SYNC_SECOND_RESET;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   framed_packet_parser_crc16_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_frame_size     (rsp_frame_size),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   fpp_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_frame_size     (rsp_frame_size),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // A long hold-off is started by the stimulus and counted down here.
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] frame_crc(input logic [7:0] q[$]);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 2; i < q.size(); i++) begin
         c = c ^ {q[i], 8'h00};
         for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] gap_ms(input bit wide);
      int unsigned r;
      int unsigned cap;
      r = $urandom_range(99);
      cap = (cur_timeout < 40) ? cur_timeout : 40;
      if (wide && r < 20) return $urandom();
      if (wide && r < 30) return 32'(cur_timeout) + 1;
      if (r < 8) return 32'(cur_timeout);
      return $urandom_range(cap, 0);
   endfunction

   // Entered just after a rising edge; returns at the edge that takes the word.
   task automatic put_word(input logic [7:0] b, input logic [31:0] t);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_now_ms <= t;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic tick_word(input logic [7:0] b);
      stamp_ms = stamp_ms + 1;
      put_word(b, stamp_ms);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_bytes(input logic [7:0] q[$], input int late_at, input bit steady);
      for (int i = 0; i < q.size(); i++) begin
         if (steady) stamp_ms = stamp_ms + 1;
         else if (i == late_at)
            stamp_ms = stamp_ms + 32'(cur_timeout) + 1 + $urandom_range(2000, 0);
         else stamp_ms = stamp_ms + gap_ms(i == 0);
         put_word(q[i], stamp_ms);
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input int len, input bit steady);
      logic [7:0]  q[$];
      logic [15:0] c;
      int          late_at;
      q = {cur_first, cur_second};
      if (kind == FK_OVERSIZE) begin
         q.push_back(8'($urandom_range(255, MAX_PAYLOAD + 1)));
         send_bytes(q, -1, steady);
         return;
      end
      q.push_back(8'(len));
      q.push_back(8'($urandom_range(255, 0)));
      q.push_back(8'($urandom_range(255, 0)));
      for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(255, 0)));
      c = frame_crc(q);
      case (kind)
         FK_BAD_CRC:      c = c ^ 16'($urandom_range(65535, 1));
         FK_RESYNC_PAIR:  c = {cur_second, cur_first};
         FK_RESYNC_FIRST: c = {cur_first, 8'($urandom_range(255, 0))};
         default: ;
      endcase
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
      late_at = (kind == FK_LATE) ? $urandom_range(q.size() - 1, 1) : -1;
      send_bytes(q, late_at, steady);
   endtask

   task automatic send_noise();
      logic [7:0] q[$];
      int         n;
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++)
         q.push_back(($urandom_range(3) == 0) ? cur_first : 8'($urandom_range(255, 0)));
      send_bytes(q, -1, 1'b0);
   endtask

   task automatic random_traffic(input int target);
      int unsigned r;
      int          len;
      while (words_sent < target) begin
         r = $urandom_range(99);
         len = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD, 9) : $urandom_range(8, 0);
         if (r < 55) send_frame(FK_GOOD, len, 1'b0);
         else if (r < 65) send_frame(FK_BAD_CRC, len, 1'b0);
         else if (r < 72) send_frame(FK_RESYNC_PAIR, len, 1'b0);
         else if (r < 79) send_frame(FK_RESYNC_FIRST, len, 1'b0);
         else if (r < 85) send_frame(FK_OVERSIZE, len, 1'b0);
         else if (r < 92) send_frame(FK_LATE, len, 1'b0);
         else send_noise();
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TIMEOUT:     cur_timeout = val;
         CSR_SYNC_FIRST:  cur_first = val[7:0];
         CSR_SYNC_SECOND: cur_second = val[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] tmo, input logic [7:0] a, input logic [7:0] b);
      release_req();
      wait (pending_count == 0);
      repeat (12) @(negedge clock);
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_SYNC_FIRST, {8'($urandom_range(255, 0)), a});
      write_reg(CSR_SYNC_SECOND, {8'($urandom_range(255, 0)), b});
   endtask

   initial begin
      stamp_ms = 32'hFFFF_FFFD;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tick_word(8'h00);
      tick_word(8'hFF);
      tick_word(cur_first);
      tick_word(cur_first);
      tick_word(cur_second);
      tick_word(8'hFF);
      send_frame(FK_GOOD, 0, 1'b1);
      send_frame(FK_RESYNC_PAIR, 2, 1'b1);
      stamp_ms = stamp_ms + 32'(cur_timeout) + 5;
      put_word(cur_first, stamp_ms);
      tick_word(8'h33);

      random_traffic(50);
      hold_asks++;
      send_frame(FK_GOOD, 12, 1'b0);
      release_req();
      wait (pending_count == 0);
      random_traffic(85);

      configure(16'd0, 8'h00, 8'hFF);
      random_traffic(105);
      configure(16'hFFFF, 8'h7E, 8'h7E);
      no_idle = 1'b1;
      random_traffic(130);
      no_idle = 1'b0;
      configure(16'($urandom_range(2000, 1)), 8'($urandom_range(255, 0)),
                8'($urandom_range(255, 0)));
      random_traffic(155);

      release_req();
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_ctrl.sv
hw/rtl/fpp_datapath.sv
hw/rtl/framed_packet_parser_crc16_unit.sv
tb/fpp_checker.sv
tb/testbench.sv
